// ===== rtl/hsd_pkg.sv =====
// shared types and constants for the huffman stream decoder
package hsd_pkg;

	localparam int MAX_LEAVES  = 256;
	localparam int NODE_SLOTS  = 2 * MAX_LEAVES - 1;
	localparam int STACK_LIMIT = MAX_LEAVES - 1;
	localparam int IDX_W       = $clog2(NODE_SLOTS);
	localparam int NT_W        = $clog2(NODE_SLOTS + 1);
	localparam int D_W         = $clog2(MAX_LEAVES);
	localparam int HDR_BITS    = 3;
	localparam int SYM_BITS    = 8;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_TREE    = 2'd1,
		PH_DATA    = 2'd2,
		PH_DISCARD = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_SHORT     = 2'd2
	} status_t;

	typedef struct packed {
		logic load;
		logic step;
		logic pop_load;
		logic walk_eval;
		logic end_emit;
		logic flush;
	} hsd_cmd_t;

	typedef struct packed {
		logic stop;
		logic kind_pop;
		logic kind_walk;
		logic kind_emit;
		logic emit_ok;
		logic out_free;
		logic pend_v;
		logic final_in;
	} hsd_stat_t;

endpackage

// ===== rtl/hsd_ctrl.sv =====
// sequencer that walks one input byte bit by bit
module hsd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  hsd_pkg::hsd_stat_t stat,
	output hsd_pkg::hsd_cmd_t  cmd
);
	import hsd_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_BIT   = 6'b000010,
		S_POP   = 6'b000100,
		S_WALK  = 6'b001000,
		S_FIN   = 6'b010000,
		S_FLUSH = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_BIT;
				end
			end
			S_BIT: begin
				if (stat.stop) begin
					state_d = S_FIN;
				end else if (!stat.kind_emit || stat.emit_ok) begin
					cmd.step = 1'b1;
					if (stat.kind_pop)
						state_d = S_POP;
					else if (stat.kind_walk)
						state_d = S_WALK;
				end
			end
			S_POP: begin
				cmd.pop_load = 1'b1;
				state_d      = S_BIT;
			end
			S_WALK: begin
				if (stat.emit_ok) begin
					cmd.walk_eval = 1'b1;
					state_d       = S_BIT;
				end
			end
			S_FIN: begin
				if (!stat.final_in) begin
					state_d = S_FLUSH;
				end else if (stat.emit_ok) begin
					cmd.end_emit = 1'b1;
					state_d      = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (!stat.pend_v) begin
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

// ===== rtl/hsd_datapath.sv =====
// tree store, pending-parent stack, walk registers and output staging
module hsd_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  hsd_pkg::hsd_cmd_t  cmd,
	output hsd_pkg::hsd_stat_t stat,
	input  logic [7:0]         stream_byte,
	input  logic               final_byte,
	output logic [7:0]         symbol,
	output logic               run_last,
	output logic               end_of_stream,
	output logic [1:0]         status,
	output logic               out_valid,
	input  logic               out_stall
);
	import hsd_pkg::*;

	// node store split by field so each part takes one write per cycle
	logic             leaf_mem  [NODE_SLOTS];
	logic [7:0]       sym_mem   [NODE_SLOTS];
	logic [IDX_W-1:0] left_mem  [NODE_SLOTS];
	logic [IDX_W-1:0] right_mem [NODE_SLOTS];
	logic [IDX_W:0]   stk_mem   [MAX_LEAVES];

	logic             rd_leaf_q;
	logic [7:0]       rd_sym_q;
	logic [IDX_W-1:0] rd_l_q, rd_r_q;
	logic [IDX_W:0]   stk_rd_q;

	phase_t           phase_q;
	logic [2:0]       lvb_q;
	logic [1:0]       hbs_q;
	logic [NT_W-1:0]  nt_q;
	logic [D_W-1:0]   d_q;
	logic [IDX_W-1:0] tos_idx_q;
	logic             tos_fill_q;
	logic [7:0]       symsh_q;
	logic [3:0]       symcnt_q;
	logic             root_leaf_q;
	logic [7:0]       root_sym_q;
	logic [IDX_W-1:0] root_l_q, root_r_q, cur_l_q, cur_r_q;
	logic             at_root_q;
	logic             err_q;
	logic [7:0]       byte_q;
	logic             fin_q;
	logic [3:0]       cnt_q;
	logic             pend_v_q, pend_end_q;
	logic [7:0]       pend_sym_q;
	status_t          pend_st_q;
	logic             out_v_q;

	logic             bit_in;
	logic [3:0]       lim;
	logic [IDX_W-1:0] idx, last_idx, ch_l, ch_r, next_addr;
	logic [D_W-1:0]   stk_wr_addr, stk_rd_addr;
	logic             in_node, node_fail, node_wr, sym_done;
	logic             emit_fire, out_load, out_free;
	logic [7:0]       new_sym, done_sym;
	status_t          new_st;

	assign bit_in    = byte_q[7];
	assign lim       = (lvb_q == 3'd0) ? 4'd8 : {1'b0, lvb_q};
	assign idx       = nt_q[IDX_W-1:0];
	assign last_idx  = IDX_W'(nt_q - 1'b1);
	assign done_sym  = {symsh_q[6:0], bit_in};
	assign in_node   = (phase_q == PH_TREE) && (symcnt_q == 4'd0);
	assign node_fail = in_node && ((nt_q == NT_W'(NODE_SLOTS))
		|| (bit_in && (d_q == D_W'(STACK_LIMIT))));
	assign node_wr   = cmd.step && in_node && !node_fail;
	assign sym_done  = cmd.step && (phase_q == PH_TREE) && (symcnt_q == 4'(SYM_BITS));
	assign ch_l      = at_root_q ? root_l_q : cur_l_q;
	assign ch_r      = at_root_q ? root_r_q : cur_r_q;
	assign next_addr = bit_in ? ch_r : ch_l;
	assign stk_wr_addr = D_W'({1'b0, d_q} - (D_W+1)'(1));
	assign stk_rd_addr = D_W'({1'b0, d_q} - (D_W+1)'(2));

	assign out_free = !out_v_q || !out_stall;

	always_comb begin
		stat           = '0;
		stat.stop      = (cnt_q == 4'd8)
			|| (fin_q && (hbs_q == 2'(HDR_BITS)) && (cnt_q >= lim));
		stat.kind_pop  = in_node && !node_fail && (d_q != '0) && tos_fill_q && !bit_in;
		stat.kind_walk = (phase_q == PH_DATA) && !root_leaf_q;
		stat.kind_emit = (phase_q == PH_DATA) && root_leaf_q && !bit_in;
		stat.out_free  = out_free;
		stat.emit_ok   = !pend_v_q || out_free;
		stat.pend_v    = pend_v_q;
		stat.final_in  = fin_q;
	end

	// node store, child read captured with the bit so a stalled walk keeps it
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			rd_leaf_q <= leaf_mem[next_addr];
			rd_sym_q  <= sym_mem[next_addr];
			rd_l_q    <= left_mem[next_addr];
			rd_r_q    <= right_mem[next_addr];
		end
		if (node_wr)
			leaf_mem[idx] <= !bit_in;
		if (sym_done)
			sym_mem[last_idx] <= done_sym;
		if (node_wr && (d_q != '0) && !tos_fill_q)
			left_mem[tos_idx_q] <= idx;
		if (node_wr && (d_q != '0) && tos_fill_q)
			right_mem[tos_idx_q] <= idx;
	end

	// pending-parent stack below the top entry
	always_ff @(posedge clk) begin
		stk_rd_q <= stk_mem[stk_rd_addr];
		if (node_wr && bit_in && (d_q != '0) && !tos_fill_q)
			stk_mem[stk_wr_addr] <= {1'b1, tos_idx_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			lvb_q       <= '0;
			hbs_q       <= '0;
			nt_q        <= '0;
			d_q         <= '0;
			tos_idx_q   <= '0;
			tos_fill_q  <= 1'b0;
			symsh_q     <= '0;
			symcnt_q    <= '0;
			root_leaf_q <= 1'b0;
			root_sym_q  <= '0;
			root_l_q    <= '0;
			root_r_q    <= '0;
			cur_l_q     <= '0;
			cur_r_q     <= '0;
			at_root_q   <= 1'b1;
			err_q       <= 1'b0;
			byte_q      <= '0;
			fin_q       <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cmd.load) begin
				byte_q <= stream_byte;
				fin_q  <= final_byte;
				cnt_q  <= '0;
			end
			if (cmd.step) begin
				byte_q <= {byte_q[6:0], 1'b0};
				cnt_q  <= cnt_q + 4'd1;
				case (phase_q)
					PH_HEADER: begin
						lvb_q <= {lvb_q[1:0], bit_in};
						hbs_q <= hbs_q + 2'd1;
						if (hbs_q == 2'(HDR_BITS - 1))
							phase_q <= PH_TREE;
					end
					PH_TREE: begin
						if (symcnt_q != 4'd0) begin
							if (sym_done) begin
								symsh_q  <= '0;
								symcnt_q <= '0;
								if (last_idx == '0)
									root_sym_q <= done_sym;
								if (d_q == '0) begin
									phase_q   <= PH_DATA;
									at_root_q <= 1'b1;
								end
							end else begin
								symsh_q  <= done_sym;
								symcnt_q <= symcnt_q + 4'd1;
							end
						end else if (node_fail) begin
							err_q   <= 1'b1;
							phase_q <= PH_DISCARD;
						end else begin
							nt_q <= nt_q + 1'b1;
							if (idx == '0)
								root_leaf_q <= !bit_in;
							if (!bit_in) begin
								symcnt_q <= 4'd1;
								symsh_q  <= '0;
							end
							if (d_q != '0) begin
								if (tos_fill_q) begin
									if (tos_idx_q == '0)
										root_r_q <= idx;
									if (bit_in) begin
										tos_idx_q  <= idx;
										tos_fill_q <= 1'b0;
									end else begin
										// pop, the new top is loaded from the stack in S_POP
										d_q <= d_q - 1'b1;
									end
								end else begin
									if (tos_idx_q == '0)
										root_l_q <= idx;
									if (bit_in) begin
										d_q        <= d_q + 1'b1;
										tos_idx_q  <= idx;
										tos_fill_q <= 1'b0;
									end else begin
										tos_fill_q <= 1'b1;
									end
								end
							end else if (bit_in) begin
								d_q        <= D_W'(1);
								tos_idx_q  <= idx;
								tos_fill_q <= 1'b0;
							end
						end
					end
					PH_DATA: begin
						// a one bit on a single-leaf tree
						if (root_leaf_q && bit_in) begin
							err_q   <= 1'b1;
							phase_q <= PH_DISCARD;
						end
					end
					default: ;
				endcase
			end
			if (cmd.pop_load) begin
				tos_fill_q <= stk_rd_q[IDX_W];
				tos_idx_q  <= stk_rd_q[IDX_W-1:0];
			end
			if (cmd.walk_eval) begin
				if (rd_leaf_q) begin
					at_root_q <= 1'b1;
				end else begin
					at_root_q <= 1'b0;
					cur_l_q   <= rd_l_q;
					cur_r_q   <= rd_r_q;
				end
			end
			if (cmd.end_emit) begin
				phase_q   <= PH_HEADER;
				lvb_q     <= '0;
				hbs_q     <= '0;
				nt_q      <= '0;
				d_q       <= '0;
				symsh_q   <= '0;
				symcnt_q  <= '0;
				at_root_q <= 1'b1;
				err_q     <= 1'b0;
			end
		end
	end

	// one item is held back so the last one of a byte can carry run_last
	assign emit_fire = (cmd.step && stat.kind_emit) || (cmd.walk_eval && rd_leaf_q)
		|| cmd.end_emit;
	assign out_load  = (emit_fire && pend_v_q) || cmd.flush;

	always_comb begin
		new_sym = root_sym_q;
		new_st  = ST_OK;
		if (cmd.end_emit) begin
			new_sym = '0;
			if (err_q)
				new_st = ST_MALFORMED;
			else if ((phase_q == PH_HEADER) || (phase_q == PH_TREE))
				new_st = ST_SHORT;
		end else if (cmd.walk_eval) begin
			new_sym = rd_sym_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (emit_fire)
				pend_v_q <= 1'b1;
			else if (cmd.flush)
				pend_v_q <= 1'b0;
			if (out_load)
				out_v_q <= 1'b1;
			else if (!out_stall)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			pend_sym_q <= new_sym;
			pend_end_q <= cmd.end_emit;
			pend_st_q  <= new_st;
		end
		if (out_load) begin
			symbol        <= pend_sym_q;
			end_of_stream <= pend_end_q;
			status        <= pend_st_q;
			run_last      <= cmd.flush;
		end
	end

	assign out_valid = out_v_q;

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		d_q <= D_W'(STACK_LIMIT)) else $error("pending stack past its limit");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_v_q) |-> !out_stall) else $error("stalled output overwritten");
	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !pend_v_q) else $error("new byte taken with an item held back");
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.flush) |-> (out_v_q && run_last)) else $error("flush lost run_last");

endmodule

// ===== rtl/huffman_stream_decoder.sv =====
// top level of the huffman stream decoder
//
//  channel  signals                                          direction
//  in       stream_byte, final_byte, in_valid / in_stall     byte into the block
//  out      symbol, run_last, end_of_stream, status,
//           out_valid / out_stall                            items out of the block
//
// a byte is loaded, then takes a step per header, tree or discarded bit, a step
// and a walk per data bit on a tree of more than one leaf (registered node-store
// read), a pop state for a stack pop, and closes with stop, end item and flush
// arst_n clears the phase, counters and stack depth; the memories are not cleared
// a stalled output holds the next emission and with it the bit walk
module huffman_stream_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] stream_byte,
	input  logic       final_byte,
	input  logic       in_valid,
	output logic       in_stall,
	output logic [7:0] symbol,
	output logic       run_last,
	output logic       end_of_stream,
	output logic [1:0] status,
	output logic       out_valid,
	input  logic       out_stall
);
	import hsd_pkg::*;

	hsd_cmd_t  cmd;
	hsd_stat_t stat;

	hsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	hsd_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.stream_byte   (stream_byte),
		.final_byte    (final_byte),
		.symbol        (symbol),
		.run_last      (run_last),
		.end_of_stream (end_of_stream),
		.status        (status),
		.out_valid     (out_valid),
		.out_stall     (out_stall)
	);

endmodule
